/* design/dmbi_pkg.sv */
// Shared types and constants of the dual-mode DRAM bus interface.
// Holds the request and response structs, command codes and address windows.
// Depends on nothing; the top, the decoder and the store import it.
package dmbi_pkg;

  // Sizes of the byte store and the internal register window.
  localparam int unsigned MemBytesDefault = 2097152;
  localparam int unsigned RegCountDefault = 32;

  // Address windows on the 24-bit bus.
  localparam logic [23:0] WinLowEnd    = 24'h080000;
  localparam logic [23:0] WinHighStart = 24'h180000;
  localparam logic [23:0] WinHighEnd   = 24'h1FFC00;
  localparam logic [23:0] MregBase     = 24'h1FFFE0;
  localparam logic [23:0] SlaveEnd     = 24'h100000;
  localparam logic [23:0] SregBase     = 24'h1FFFC0;
  localparam logic [23:0] SwapOffset   = 24'h180000;
  localparam logic [2:0]  SwapLimit    = 3'd4;
  localparam logic [15:0] RegHighMask  = 16'hFF00;

  // Bus command codes.
  typedef enum logic [2:0] {
    CMD_RD_BYTE = 3'd0,
    CMD_RD_WORD = 3'd1,
    CMD_RD_LONG = 3'd2,
    CMD_WR_BYTE = 3'd3,
    CMD_WR_WORD = 3'd4,
    CMD_WR_LONG = 3'd5
  } cmd_e;

  // Access size.
  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_e;

  // One bus request.
  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] address;
    logic [31:0] write_data;
  } req_t;

  // One bus response.
  typedef struct packed {
    logic [31:0] read_data;
    logic        in_range;
  } rsp_t;

  // Decoded request.
  typedef struct packed {
    logic  rd;
    logic  wr;
    logic  mem_hit;
    logic  reg_hit;
    logic  swap;
    size_e size;
  } dec_t;

endpackage

/* design/dual_mode_dram_bus_interface_top.sv */
// A request's response passes through the bank read and stage-one registers, then the
// response register, which drives strobe_o and rsp_o.
// Throughput: one request per cycle; the store's four byte banks each serve one
// byte per cycle with a registered read, and the response register follows them.
// Reset clears the mode to master, the boot swap counter and the registers.
// The byte store is not cleared; the receiver cannot stall the response.
module dual_mode_dram_bus_interface_top import dmbi_pkg::*; #(
  parameter int unsigned MemBytes = MemBytesDefault,
  parameter int unsigned RegCount = RegCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic strobe_o,
  output rsp_t rsp_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  localparam int unsigned AW = $clog2(MemBytes);
  localparam int unsigned IW = $clog2(RegCount);

  logic           accept;
  logic           is_master_q;
  logic [2:0]     swap_cnt_q;
  logic [2:0]     swap_cnt_d;
  dec_t           dec;
  logic [AW-1:0]  phys;
  logic [IW-1:0]  reg_idx;
  logic [15:0]    regs_q [RegCount];
  logic [31:0]    mem_rdata;
  logic           s1_valid_q;
  logic           s1_mem_q;
  logic           s1_reg_q;
  logic           s1_hit_q;
  logic [7:0]     s1_regbyte_q;
  logic           strobe_q;
  rsp_t           rsp_q;
  rsp_t           rsp_d;

  // The pipeline takes a request every cycle.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_master_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      is_master_q <= cfg_data_i;
    end
  end

  dmbi_decode #(
    .MemBytes(MemBytes),
    .RegCount(RegCount)
  ) u_decode (
    .req_i      (req_i),
    .is_master_i(is_master_q),
    .swap_cnt_i (swap_cnt_q),
    .dec_o      (dec),
    .phys_o     (phys),
    .reg_idx_o  (reg_idx)
  );

  // Boot swap counter: words count one, longs two.
  always_comb begin
    swap_cnt_d = swap_cnt_q;
    if (accept && dec.swap) begin
      swap_cnt_d = swap_cnt_q + ((dec.size == SZ_LONG) ? 3'd2 : 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_cnt_q <= 3'd0;
    end else begin
      swap_cnt_q <= swap_cnt_d;
    end
  end

  // Internal registers; a byte write keeps the high byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= 16'h0;
      end
    end else if (accept && dec.wr && dec.reg_hit) begin
      if (dec.size == SZ_BYTE) begin
        regs_q[reg_idx] <= (regs_q[reg_idx] & RegHighMask) | {8'h0, req_i.write_data[7:0]};
      end else begin
        regs_q[reg_idx] <= req_i.write_data[15:0];
      end
    end
  end

  dmbi_store #(
    .MemBytes(MemBytes)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (accept && dec.rd && dec.mem_hit),
    .wr_i   (accept && dec.wr && dec.mem_hit),
    .addr_i (phys),
    .size_i (dec.size),
    .wdata_i(req_i.write_data),
    .rdata_o(mem_rdata)
  );

  // Stage one: wait for the bank read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mem_q   <= 1'b0;
      s1_reg_q   <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_mem_q   <= accept && dec.rd && dec.mem_hit;
      s1_reg_q   <= accept && dec.rd && dec.reg_hit;
      s1_hit_q   <= accept && (dec.mem_hit || dec.reg_hit);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_regbyte_q <= regs_q[reg_idx][7:0];
  end

  // Response select.
  always_comb begin
    rsp_d.in_range = s1_hit_q;
    priority if (s1_mem_q) begin
      rsp_d.read_data = mem_rdata;
    end else if (s1_reg_q) begin
      rsp_d.read_data = {24'h0, s1_regbyte_q};
    end else begin
      rsp_d.read_data = 32'h0;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

`ifndef SYNTHESIS
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 strobe_o)
    else $error("request not answered two cycles later");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swap_cnt_q <= 3'd5)
    else $error("boot swap counter out of bounds");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(swap_cnt_q))
    else $error("boot swap counter moved without a request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !rsp_o.in_range) |-> (rsp_o.read_data == 32'h0))
    else $error("miss returned nonzero data");
`endif

endmodule

/* design/dmbi_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// Used for each byte bank of the store; depends on nothing.
module dmbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, or registered read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dmbi_decode.sv */
// Request decoder: address windows, boot swap and physical store address.
// Depends on dmbi_pkg.
module dmbi_decode import dmbi_pkg::*; #(
  parameter int unsigned MemBytes = MemBytesDefault,
  parameter int unsigned RegCount = RegCountDefault
) (
  input  req_t                        req_i,
  input  logic                        is_master_i,
  input  logic [2:0]                  swap_cnt_i,
  output dec_t                        dec_o,
  output logic [$clog2(MemBytes)-1:0] phys_o,
  output logic [$clog2(RegCount)-1:0] reg_idx_o
);

  localparam int unsigned AW = $clog2(MemBytes);
  localparam int unsigned IW = $clog2(RegCount);

  logic [23:0] a;
  logic        rmem;
  logic        wmem;
  logic        rhit;
  logic [24:0] reg_base;
  logic        swap_ok;
  logic [23:0] swap_addr;

  assign a = req_i.address;

  // Memory windows for the current mode.
  always_comb begin
    if (is_master_i) begin
      rmem = (a < WinLowEnd) || ((a >= WinHighStart) && (a < WinHighEnd));
      wmem = (a < WinLowEnd);
    end else begin
      rmem = (a >= WinLowEnd) && (a < SlaveEnd);
      wmem = rmem;
    end
  end

  // Register window for the current mode.
  assign reg_base  = {1'b0, (is_master_i ? MregBase : SregBase)};
  assign rhit      = ({1'b0, a} >= reg_base) && ({1'b0, a} < reg_base + 25'(RegCount));
  assign reg_idx_o = IW'(a - reg_base[23:0]);

  // Boot swap redirects word and long reads until the counter reaches or passes its limit.
  assign swap_ok   = (swap_cnt_i < SwapLimit);
  assign swap_addr = a + SwapOffset;

  // Command decode.
  always_comb begin
    dec_o      = '0;
    dec_o.size = SZ_BYTE;
    phys_o     = a[AW-1:0];
    unique case (req_i.command)
      CMD_RD_BYTE: begin
        dec_o.rd      = 1'b1;
        dec_o.mem_hit = rmem;
        dec_o.reg_hit = !rmem && rhit;
      end
      CMD_RD_WORD, CMD_RD_LONG: begin
        dec_o.rd      = 1'b1;
        dec_o.size    = (req_i.command == CMD_RD_WORD) ? SZ_WORD : SZ_LONG;
        dec_o.swap    = swap_ok;
        dec_o.mem_hit = swap_ok || rmem;
        if (swap_ok) begin
          phys_o = swap_addr[AW-1:0];
        end
      end
      CMD_WR_BYTE, CMD_WR_WORD: begin
        dec_o.wr      = 1'b1;
        dec_o.size    = (req_i.command == CMD_WR_BYTE) ? SZ_BYTE : SZ_WORD;
        dec_o.mem_hit = wmem;
        dec_o.reg_hit = !wmem && rhit;
      end
      CMD_WR_LONG: begin
        dec_o.wr      = 1'b1;
        dec_o.size    = SZ_LONG;
        dec_o.mem_hit = wmem;
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule

/* design/dmbi_store.sv */
// Byte store split into four byte banks so that any byte, word or long
// access, aligned or not, touches each bank at most once. Depends on
// dmbi_pkg and dmbi_ram.
module dmbi_store import dmbi_pkg::*; #(
  parameter int unsigned MemBytes = MemBytesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_i,
  input  logic                        wr_i,
  input  logic [$clog2(MemBytes)-1:0] addr_i,
  input  size_e                       size_i,
  input  logic [31:0]                 wdata_i,
  output logic [31:0]                 rdata_o
);

  localparam int unsigned AW    = $clog2(MemBytes);
  localparam int unsigned RW    = AW - 2;
  localparam int unsigned Depth = MemBytes / 4;

  logic [1:0]       lane;
  logic [3:0][7:0]  wr_al;
  logic [3:0][7:0]  dout;
  logic [3:0][7:0]  top;
  logic [1:0]       lane_q;
  size_e            size_q;

  assign lane = addr_i[1:0];

  // Left-align the write data so that byte 0 of the access sits on top.
  always_comb begin
    unique case (size_i)
      SZ_BYTE: wr_al = {wdata_i[7:0], 24'h0};
      SZ_WORD: wr_al = {wdata_i[15:0], 16'h0};
      SZ_LONG: wr_al = wdata_i;
      default: wr_al = wdata_i;
    endcase
  end

  // One bank per low address bit pair.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]    k;
    logic          act;
    logic [RW-1:0] row;

    assign k   = 2'(b) - lane;
    assign row = addr_i[AW-1:2] + RW'(2'(b) < lane);

    always_comb begin
      unique case (size_i)
        SZ_BYTE: act = (k == 2'd0);
        SZ_WORD: act = (k <= 2'd1);
        SZ_LONG: act = 1'b1;
        default: act = 1'b0;
      endcase
    end

    dmbi_ram #(
      .Width(8),
      .Depth(Depth)
    ) u_ram (
      .clk_i  (clk_i),
      .en_i   ((rd_i || wr_i) && act),
      .we_i   (wr_i),
      .addr_i (row),
      .wdata_i(wr_al[2'd3 - k]),
      .rdata_o(dout[b])
    );
  end

  // Lane and size of the read in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= 2'd0;
      size_q <= SZ_BYTE;
    end else if (rd_i) begin
      lane_q <= lane;
      size_q <= size_i;
    end
  end

  // Gather bank outputs in big-endian order, then right-align.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      top[3 - k] = dout[lane_q + 2'(k)];
    end
    unique case (size_q)
      SZ_BYTE: rdata_o = {24'h0, top[3]};
      SZ_WORD: rdata_o = {16'h0, top[3], top[2]};
      SZ_LONG: rdata_o = top;
      default: rdata_o = '0;
    endcase
  end

endmodule
